/* sv/clp_pkg.sv */
// shared types and constants for the combined log line parser
// no dependencies; used by the channel interfaces and the parser
`default_nettype none

package clp_pkg;

    localparam int BYTE_W   = 8;
    localparam int TAG_W    = 4;
    localparam int STATUS_W = 32;
    localparam int SIZE_W   = 64;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CHR_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CHR_RBRACK = 8'h5D;

    localparam logic [TAG_W-1:0] TAG_NONE     = 4'd0;
    localparam logic [TAG_W-1:0] TAG_ADDR     = 4'd1;
    localparam logic [TAG_W-1:0] TAG_IDENT    = 4'd2;
    localparam logic [TAG_W-1:0] TAG_USER     = 4'd3;
    localparam logic [TAG_W-1:0] TAG_TIME     = 4'd4;
    localparam logic [TAG_W-1:0] TAG_METHOD   = 4'd5;
    localparam logic [TAG_W-1:0] TAG_URL      = 4'd6;
    localparam logic [TAG_W-1:0] TAG_PROTO    = 4'd7;
    localparam logic [TAG_W-1:0] TAG_REFERER  = 4'd8;
    localparam logic [TAG_W-1:0] TAG_AGENT    = 4'd9;
    localparam logic [TAG_W-1:0] TAG_STATUS   = 4'd10;
    localparam logic [TAG_W-1:0] TAG_SIZE     = 4'd11;

    typedef enum logic [22:0] {
        PH_ADDR        = 23'h000001,
        PH_IDENT       = 23'h000002,
        PH_USER        = 23'h000004,
        PH_TIME_OPEN   = 23'h000008,
        PH_TIME        = 23'h000010,
        PH_SP_TIME     = 23'h000020,
        PH_REQ_OPEN    = 23'h000040,
        PH_METHOD      = 23'h000080,
        PH_URL         = 23'h000100,
        PH_PROTO       = 23'h000200,
        PH_SP_REQ      = 23'h000400,
        PH_STAT_START  = 23'h000800,
        PH_STAT_MINUS  = 23'h001000,
        PH_STAT_DIGITS = 23'h002000,
        PH_SIZE_START  = 23'h004000,
        PH_SIZE_DIGITS = 23'h008000,
        PH_SIZE_DASH   = 23'h010000,
        PH_REF_OPEN    = 23'h020000,
        PH_REFERER     = 23'h040000,
        PH_SP_REF      = 23'h080000,
        PH_AGENT_OPEN  = 23'h100000,
        PH_AGENT       = 23'h200000,
        PH_DONE        = 23'h400000
    } phase_t;

    typedef struct packed {
        logic [TAG_W-1:0]           field_tag;
        logic                       line_done;
        logic                       line_ok;
        logic signed [STATUS_W-1:0] status_code;
        logic [SIZE_W-1:0]          response_size;
    } result_t;

endpackage

`default_nettype wire

/* sv/clp_in_if.sv */
// request channel carrying one log byte or an end-of-line marker
// depends on clp_pkg
`default_nettype none

interface clp_in_if;
    import clp_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

/* sv/clp_out_if.sv */
// result channel carrying the field tag of a byte or the verdict of a line
// depends on clp_pkg
`default_nettype none

interface clp_out_if;
    import clp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [TAG_W-1:0]           field_tag;
    logic                       line_done;
    logic                       line_ok;
    logic signed [STATUS_W-1:0] status_code;
    logic [SIZE_W-1:0]          response_size;

    modport source (output valid, output field_tag, output line_done, output line_ok,
                    output status_code, output response_size, input ready);
    modport sink   (input valid, input field_tag, input line_done, input line_ok,
                    input status_code, input response_size, output ready);
endinterface

`default_nettype wire

/* sv/combined_log_line_parser.sv */
// Streaming parser for one combined-format access-log line. Every request (a data byte or
// an end-of-line marker) produces exactly one result, in the cycle after it is taken: a byte
// gets the tag of the field it belongs to, the end-of-line marker gets the pass/fail verdict
// with the parsed status and response size, and the parser then returns to the start of a
// line. One request is taken every cycle; the only thing that holds item.ready low is a
// result sitting unread in the result register. The status and size accumulate by a
// shift-and-add per digit, so a digit costs no more than any other byte.
// depends on clp_pkg, clp_in_if, clp_out_if
`default_nettype none

module combined_log_line_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clp_in_if.sink     item,
    clp_out_if.source  result
);
    import clp_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  seen_reg, seen_next;
    logic                  neg_reg, neg_next;
    logic [STATUS_W-1:0]   mag_reg, mag_next;
    logic [SIZE_W-1:0]     acc_reg, acc_next;
    logic                  dash_reg, dash_next;
    logic                  failed_reg, failed_next;

    logic                  out_valid_reg;
    result_t               res_reg, res_next;

    logic                  accept;
    logic [BYTE_W-1:0]     b;
    logic                  is_space;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [STATUS_W+3:0]   stat_val;
    logic [STATUS_W+3:0]   stat_limit;
    logic                  stat_fits;
    logic [SIZE_W+3:0]     size_val;
    logic                  size_fits;
    logic [TAG_W-1:0]      tag;
    logic                  fail;
    logic                  tok_active;
    logic [TAG_W-1:0]      tok_tag;
    phase_t                tok_next;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign b        = item.data_byte;
    assign is_space = (b == CHR_SPACE);
    assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
    assign digit    = b[3:0];

    assign stat_val   = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                      + {{(STATUS_W){1'b0}}, digit};
    assign stat_limit = neg_reg ? 36'd2147483648 : 36'd2147483647;
    assign stat_fits  = (stat_val <= stat_limit);

    assign size_val  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{(SIZE_W){1'b0}}, digit};
    assign size_fits = (size_val[SIZE_W+3:SIZE_W] == 4'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        acc_next    = acc_reg;
        dash_next   = dash_reg;
        failed_next = failed_reg;
        tag         = TAG_NONE;
        fail        = 1'b0;
        tok_active  = 1'b0;
        tok_tag     = TAG_NONE;
        tok_next    = phase_reg;
        res_next    = '0;

        if (item.opcode == OP_EOL)
        begin
            res_next.line_done = 1'b1;
            if (!failed_reg && phase_reg == PH_DONE)
            begin
                res_next.line_ok       = 1'b1;
                res_next.status_code   = neg_reg ? (STATUS_W'(0) - mag_reg) : mag_reg;
                res_next.response_size = dash_reg ? SIZE_W'(0) : acc_reg;
            end
            phase_next  = PH_ADDR;
            seen_next   = 1'b0;
            neg_next    = 1'b0;
            mag_next    = '0;
            acc_next    = '0;
            dash_next   = 1'b0;
            failed_next = 1'b0;
        end
        else if (!failed_reg)
        begin
            unique case (phase_reg) inside
                PH_ADDR:
                begin
                    tok_active = 1'b1;
                    tok_tag    = TAG_ADDR;
                    tok_next   = PH_IDENT;
                end
                PH_IDENT:
                begin
                    tok_active = 1'b1;
                    tok_tag    = TAG_IDENT;
                    tok_next   = PH_USER;
                end
                PH_USER:
                begin
                    tok_active = 1'b1;
                    tok_tag    = TAG_USER;
                    tok_next   = PH_TIME_OPEN;
                end
                PH_TIME_OPEN:
                begin
                    if (b == CHR_LBRACK) phase_next = PH_TIME;
                    else fail = 1'b1;
                end
                PH_TIME:
                begin
                    if (b == CHR_RBRACK) phase_next = PH_SP_TIME;
                    else tag = TAG_TIME;
                end
                PH_SP_TIME:
                begin
                    if (is_space) phase_next = PH_REQ_OPEN;
                    else fail = 1'b1;
                end
                PH_REQ_OPEN:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_METHOD;
                    else fail = 1'b1;
                end
                PH_METHOD:
                begin
                    if (b == CHR_QUOTE) fail = 1'b1;
                    else
                    begin
                        tok_active = 1'b1;
                        tok_tag    = TAG_METHOD;
                        tok_next   = PH_URL;
                    end
                end
                PH_URL:
                begin
                    if (b == CHR_QUOTE) fail = 1'b1;
                    else
                    begin
                        tok_active = 1'b1;
                        tok_tag    = TAG_URL;
                        tok_next   = PH_PROTO;
                    end
                end
                PH_PROTO:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_SP_REQ;
                    else tag = TAG_PROTO;
                end
                PH_SP_REQ:
                begin
                    if (is_space) phase_next = PH_STAT_START;
                    else fail = 1'b1;
                end
                PH_STAT_START, PH_STAT_MINUS, PH_STAT_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (stat_fits)
                        begin
                            mag_next   = stat_val[STATUS_W-1:0];
                            phase_next = PH_STAT_DIGITS;
                            tag        = TAG_STATUS;
                        end
                        else fail = 1'b1;
                    end
                    else if (phase_reg == PH_STAT_START && b == CHR_DASH)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_STAT_MINUS;
                        tag        = TAG_STATUS;
                    end
                    else if (phase_reg == PH_STAT_DIGITS && is_space)
                        phase_next = PH_SIZE_START;
                    else fail = 1'b1;
                end
                PH_SIZE_START, PH_SIZE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (size_fits)
                        begin
                            acc_next   = size_val[SIZE_W-1:0];
                            dash_next  = 1'b0;
                            phase_next = PH_SIZE_DIGITS;
                            tag        = TAG_SIZE;
                        end
                        else fail = 1'b1;
                    end
                    else if (phase_reg == PH_SIZE_START && b == CHR_DASH)
                    begin
                        dash_next  = 1'b1;
                        phase_next = PH_SIZE_DASH;
                        tag        = TAG_SIZE;
                    end
                    else if (phase_reg == PH_SIZE_DIGITS && is_space)
                        phase_next = PH_REF_OPEN;
                    else fail = 1'b1;
                end
                PH_SIZE_DASH:
                begin
                    if (is_space) phase_next = PH_REF_OPEN;
                    else fail = 1'b1;
                end
                PH_REF_OPEN:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_REFERER;
                    else fail = 1'b1;
                end
                PH_REFERER:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_SP_REF;
                    else tag = TAG_REFERER;
                end
                PH_SP_REF:
                begin
                    if (is_space) phase_next = PH_AGENT_OPEN;
                    else fail = 1'b1;
                end
                PH_AGENT_OPEN:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_AGENT;
                    else fail = 1'b1;
                end
                PH_AGENT:
                begin
                    if (b == CHR_QUOTE) phase_next = PH_DONE;
                    else tag = TAG_AGENT;
                end
                PH_DONE:
                begin
                    tag = TAG_NONE;
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase

            // shared handling of space-terminated tokens
            if (tok_active)
            begin
                if (is_space)
                begin
                    if (!seen_reg) fail = 1'b1;
                    else
                    begin
                        seen_next  = 1'b0;
                        phase_next = tok_next;
                    end
                end
                else
                begin
                    seen_next = 1'b1;
                    tag       = tok_tag;
                end
            end

            if (fail)
            begin
                failed_next = 1'b1;
                tag         = TAG_NONE;
            end
            res_next.field_tag = tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR;
            seen_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            acc_reg       <= '0;
            dash_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                seen_reg   <= seen_next;
                neg_reg    <= neg_next;
                mag_reg    <= mag_next;
                acc_reg    <= acc_next;
                dash_reg   <= dash_next;
                failed_reg <= failed_next;
            end
            if (accept) out_valid_reg <= 1'b1;
            else if (result.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) res_reg <= res_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.field_tag     = res_reg.field_tag;
    assign result.line_done     = res_reg.line_done;
    assign result.line_ok       = res_reg.line_ok;
    assign result.status_code   = res_reg.status_code;
    assign result.response_size = res_reg.response_size;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_EOL |=> phase_reg == PH_ADDR && !failed_reg
            && mag_reg == '0 && acc_reg == '0)
        else $error("end of line did not restart the parser");

    a_failed_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_DATA && failed_reg |=> result.field_tag == TAG_NONE)
        else $error("byte of a failed line carries a field tag");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.line_ok |-> result.line_done && result.field_tag == TAG_NONE)
        else $error("verdict outside an end-of-line result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("request stalled with an empty result register");

endmodule

`default_nettype wire
